// File: hw/rtl/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants
// Round constants, initial hash values and the block type passed between the
// block assembler and the compression engine.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int BLOCK_WORDS = 16;
	localparam int HASH_WORDS  = 8;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] START_HASH [HASH_WORDS] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	// one assembled block plus whether it closes the message
	typedef struct packed {
		logic [BLOCK_WORDS*32-1:0] data;
		logic                      final_blk;
	} blk_t;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

endpackage

// File: hw/rtl/sha_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_front: byte intake and block assembly
// Packs bytes into 64-byte blocks, appends padding and length at message
// end and hands complete blocks on through a valid/ready pair.
// ----------------------------------------------------------------------------
module sha_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      data_byte,
	input  logic            byte_present,
	input  logic            message_end,
	input  logic            push,
	output logic            full,
	output logic            blk_valid,
	input  logic            blk_ready,
	output sha_pkg::blk_t   blk
);

	localparam logic [1:0] ST_BYTES = 2'd0;
	localparam logic [1:0] ST_PAD   = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [1:0]   state_q;
	logic [5:0]   fill_q;
	logic [63:0]  total_q;
	logic [511:0] buf_q;
	logic         fin_q;       // buffer holds the length block
	logic         end_pend_q;  // message end still to pad

	logic [8:0]   idx;
	logic         take;

	assign full = (state_q != ST_BYTES);
	assign take = push && !full;
	assign blk_valid = (state_q == ST_EMIT);
	assign blk.data = buf_q;
	assign blk.final_blk = fin_q;

	always_comb begin
		idx = {3'd0, 6'd63 - fill_q} << 3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_BYTES;
			fill_q     <= '0;
			total_q    <= '0;
			fin_q      <= 1'b0;
			end_pend_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_BYTES: begin
					if (take) begin
						if (byte_present) begin
							buf_q[idx +: 8] <= data_byte;
							total_q <= total_q + 64'd1;
							fill_q  <= fill_q + 6'd1;
						end
						if (byte_present && fill_q == 6'd63) begin
							fin_q      <= 1'b0;
							end_pend_q <= message_end;
							state_q    <= ST_EMIT;
						end else if (message_end) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// place 0x80 then zeros; length goes in when it fits
					buf_q[idx +: 8] <= sha_pkg::PAD_BYTE;
					for (int i = 0; i < 64; i++) begin
						if (i > int'(fill_q) && (i < 56 || fill_q > 6'd55)) begin
							buf_q[(63 - i) * 8 +: 8] <= 8'd0;
						end
					end
					if (fill_q <= 6'd55) begin
						buf_q[63:0] <= {total_q[60:0], 3'b000};
						fin_q <= 1'b1;
					end else begin
						fin_q <= 1'b0;
					end
					end_pend_q <= 1'b0;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (blk_ready) begin
						if (fin_q) begin
							fill_q  <= '0;
							total_q <= '0;
							state_q <= ST_BYTES;
						end else if (end_pend_q) begin
							fill_q  <= '0;
							state_q <= ST_PAD;
						end else if (fill_q != 6'd0) begin
							// overflow block after padding: zeros plus length
							buf_q   <= {448'd0, total_q[60:0], 3'b000};
							fin_q   <= 1'b1;
						end else begin
							state_q <= ST_BYTES;
						end
					end
				end
				default: state_q <= ST_BYTES;
			endcase
		end
	end

	property p_emit_full;
		@(posedge clk) disable iff (!arst_n) blk_valid |-> full;
	endproperty
	assert property (p_emit_full) else $error("block offered while intake open");

	property p_pad_to_emit;
		@(posedge clk) disable iff (!arst_n) (state_q == ST_PAD) |=> (state_q == ST_EMIT);
	endproperty
	assert property (p_pad_to_emit) else $error("padding did not produce a block");

	property p_hold;
		@(posedge clk) disable iff (!arst_n)
			(blk_valid && !blk_ready) |=> (blk_valid && $stable(buf_q));
	endproperty
	assert property (p_hold) else $error("block changed while stalled");

endmodule

// File: hw/rtl/sha_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_back: compression engine and digest output
// Runs 64 rounds, one per cycle, over each block with a rolling 16-word
// schedule, folds into the hash and streams the digest out one word a pop.
// ----------------------------------------------------------------------------
module sha_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            blk_valid,
	output logic            blk_ready,
	input  sha_pkg::blk_t   blk,
	output logic            empty,
	input  logic            pop,
	output logic [31:0]     digest_word,
	output logic [2:0]      word_index,
	output logic            last_word
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_FOLD  = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0]  state_q;
	logic [5:0]  rnd_q;
	logic [2:0]  out_q;
	logic        fin_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];

	logic [31:0] s0, s1, w_new, t1, t2, ch, mj;

	assign blk_ready   = (state_q == ST_IDLE);
	assign empty       = (state_q != ST_OUT);
	assign digest_word = h_q[out_q];
	assign word_index  = out_q;
	assign last_word   = (out_q == 3'd7);

	always_comb begin
		s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + (sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11)
			^ sha_pkg::rotr(v_q[4], 25)) + ch + sha_pkg::ROUND_K[rnd_q] + w_q[0];
		t2 = (sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13)
			^ sha_pkg::rotr(v_q[0], 22)) + mj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			out_q   <= '0;
			fin_q   <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha_pkg::START_HASH[i];
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (blk_valid) begin
						for (int i = 0; i < 16; i++) begin
							w_q[i] <= blk.data[(15 - i) * 32 +: 32];
						end
						for (int i = 0; i < 8; i++) begin
							v_q[i] <= h_q[i];
						end
						fin_q   <= blk.final_blk;
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++) begin
						w_q[i] <= w_q[i + 1];
					end
					w_q[15] <= w_new;
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q  <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					out_q   <= '0;
					state_q <= fin_q ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (pop) begin
						out_q <= out_q + 3'd1;
						if (out_q == 3'd7) begin
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= sha_pkg::START_HASH[i];
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	property p_round_count;
		@(posedge clk) disable iff (!arst_n)
			(state_q == ST_ROUND && rnd_q != 6'd63) |=> (state_q == ST_ROUND);
	endproperty
	assert property (p_round_count) else $error("round sequence cut short");

	property p_last_pop;
		@(posedge clk) disable iff (!arst_n)
			(!empty && pop && last_word) |=> (state_q == ST_IDLE);
	endproperty
	assert property (p_last_pop) else $error("digest output did not finish");

	property p_take_only_idle;
		@(posedge clk) disable iff (!arst_n)
			(blk_valid && blk_ready) |=> (state_q == ST_ROUND && rnd_q == 6'd0);
	endproperty
	assert property (p_take_only_idle) else $error("block taken without starting rounds");

endmodule

// File: hw/rtl/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher: SHA-256 over a byte stream
// Words pushed are taken back to back while a block fills. A full block goes to
// the compression engine, whose single round unit runs the 64 rounds and then
// a fold step while the next block fills behind it. Intake holds (full high)
// from the 64th byte until the engine takes the block. A message end adds a
// padding step, one or two blocks of compression and eight digest words
// popped in order, index 0 first; the engine takes no new block until the
// last digest word has been popped.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        message_end,
	input  logic        push,
	output logic        full,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word,
	output logic        empty,
	input  logic        pop
);

	logic          blk_valid;
	logic          blk_ready;
	sha_pkg::blk_t blk;

	sha_front u_front (
		.clk, .arst_n, .data_byte, .byte_present, .message_end, .push, .full,
		.blk_valid, .blk_ready, .blk
	);

	sha_back u_back (
		.clk, .arst_n, .blk_valid, .blk_ready, .blk, .empty, .pop,
		.digest_word, .word_index, .last_word
	);

endmodule

// File: test/sha256_stream_hasher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_tb: self-checking bench for the stream hasher
// Pushes byte words and message ends with random gaps, keeps its own SHA-256
// model of the hasher and checks every popped digest word in order.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;

	typedef struct {
		logic [7:0] data;
		logic       has_byte;
		logic       is_end;
	} stream_word_t;

	typedef struct {
		logic [31:0] digest;
		logic [2:0]  idx;
		logic        last;
	} digest_word_t;

	logic        clk;
	logic        arst_n;
	logic [7:0]  data_byte;
	logic        byte_present;
	logic        message_end;
	logic        push;
	logic        full;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	logic        empty;
	logic        pop;

	stream_word_t pending_words[$];
	digest_word_t expected_digests[$];

	// model state
	logic [31:0] chain[8];
	logic [7:0]  blk_bytes[64];
	int unsigned fill;
	logic [63:0] msg_bytes;

	int          errors;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_send;
	longint      cycles;

	sha256_stream_hasher i_dut (
		.clk(clk), .arst_n(arst_n), .data_byte(data_byte), .byte_present(byte_present),
		.message_end(message_end), .push(push), .full(full), .digest_word(digest_word),
		.word_index(word_index), .last_word(last_word), .empty(empty), .pop(pop)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] ror(logic [31:0] v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic compress_model();
		logic [31:0] w[64];
		logic [31:0] a[8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		a = chain;
		for (int i = 0; i < 64; i++) begin
			t1 = a[7] + (ror(a[4], 6) ^ ror(a[4], 11) ^ ror(a[4], 25))
				+ ((a[4] & a[5]) ^ (~a[4] & a[6])) + sha_pkg::ROUND_K[i] + w[i];
			t2 = (ror(a[0], 2) ^ ror(a[0], 13) ^ ror(a[0], 22))
				+ ((a[0] & a[1]) ^ (a[0] & a[2]) ^ (a[1] & a[2]));
			a[7] = a[6]; a[6] = a[5]; a[5] = a[4]; a[4] = a[3] + t1;
			a[3] = a[2]; a[2] = a[1]; a[1] = a[0]; a[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] += a[i];
	endtask

	task automatic hash_word(stream_word_t sw);
		logic [63:0] bits;
		digest_word_t d;
		if (sw.has_byte) begin
			blk_bytes[fill] = sw.data;
			fill++;
			msg_bytes++;
			if (fill == 64) begin
				compress_model();
				fill = 0;
			end
		end
		if (!sw.is_end)
			return;
		blk_bytes[fill] = sha_pkg::PAD_BYTE;
		fill++;
		if (fill > 56) begin
			for (int i = fill; i < 64; i++)
				blk_bytes[i] = 8'h00;
			compress_model();
			fill = 0;
		end
		for (int i = fill; i < 56; i++)
			blk_bytes[i] = 8'h00;
		bits = msg_bytes << 3;
		for (int i = 0; i < 8; i++)
			blk_bytes[63-i] = bits[8*i +: 8];
		compress_model();
		for (int i = 0; i < 8; i++) begin
			d.digest = chain[i];
			d.idx    = i[2:0];
			d.last   = (i == 7);
			expected_digests.push_back(d);
		end
		for (int i = 0; i < 8; i++)
			chain[i] = sha_pkg::START_HASH[i];
		fill = 0;
		msg_bytes = '0;
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic stream_word_t mk(logic [7:0] b, logic hb, logic e);
		stream_word_t s;
		s.data = b; s.has_byte = hb; s.is_end = e;
		return s;
	endfunction

	task automatic add_message(int len, bit end_with_byte);
		for (int i = 0; i < len; i++)
			pending_words.push_back(mk(8'($urandom_range(0, 255)), 1'b1,
				end_with_byte && i == len - 1));
		if (!end_with_byte || len == 0)
			pending_words.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));
	endtask

	// driver: hold the word until taken, then offer the next or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			data_byte <= '0;
			byte_present <= 1'b0;
			message_end <= 1'b0;
		end else begin
			if (!push || !full) begin
				if (push)
					hash_word(mk(data_byte, byte_present, message_end));
				if (pending_words.size() > 0 && !hold_send
						&& $urandom_range(0, 99) >= send_idle_pct) begin
					stream_word_t sw;
					sw = pending_words.pop_front();
					data_byte <= sw.data;
					byte_present <= sw.has_byte;
					message_end <= sw.is_end;
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_digests.size() == 0) begin
					report_mismatch("unexpected word", digest_word, 32'h0);
				end else begin
					digest_word_t d;
					d = expected_digests.pop_front();
					if (digest_word !== d.digest)
						report_mismatch("digest_word", digest_word, d.digest);
					if (word_index !== d.idx)
						report_mismatch("word_index", 32'(word_index), 32'(d.idx));
					if (last_word !== d.last)
						report_mismatch("last_word", 32'(last_word), 32'(d.last));
				end
			end
			pop <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("timeout");
			$display("sha256_stream_hasher_tb NOT OK");
			$finish;
		end
	end

	// look between edges so the driver and monitor have settled
	task automatic drain();
		@(negedge clk);
		while (pending_words.size() > 0 || push || expected_digests.size() > 0)
			@(negedge clk);
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		hold_send = 1'b0;
		send_idle_pct = 25;
		recv_idle_pct = 56;
		for (int i = 0; i < 8; i++)
			chain[i] = sha_pkg::START_HASH[i];
		fill = 0;
		msg_bytes = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// empty message, filler words, byte with end, extreme bytes
		pending_words.push_back(mk(8'hFF, 1'b0, 1'b0));
		pending_words.push_back(mk(8'h00, 1'b0, 1'b1));
		pending_words.push_back(mk(8'h00, 1'b1, 1'b0));
		pending_words.push_back(mk(8'h5A, 1'b0, 1'b0));
		pending_words.push_back(mk(8'hFF, 1'b1, 1'b1));
		pending_words.push_back(mk(8'hAA, 1'b1, 1'b1));
		pending_words.push_back(mk(8'h55, 1'b1, 1'b1));
		add_message(3, 1'b0);
		add_message(4, 1'b1);
		drain();

		// pause sending, then messages at the padding edges
		hold_send = 1'b1;
		repeat (20) @(posedge clk);
		hold_send = 1'b0;
		add_message(55, 1'b1);
		add_message(56, 1'b0);
		add_message(64, 1'b1);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 56 : 0;
			recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 25 : 0;
			for (int m = 0; m < 4; m++) begin
				int len;
				len = $urandom_range(0, 9);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 7) == 0)
						pending_words.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));
					pending_words.push_back(mk(8'($urandom_range(0, 255)), 1'b1,
						i == len - 1 && $urandom_range(0, 1)));
				end
				if (pending_words.size() == 0 || !pending_words[$].is_end)
					pending_words.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));
			end
			drain();
		end
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_digests.size() == 0)
			$display("sha256_stream_hasher_tb OK");
		else
			$display("sha256_stream_hasher_tb NOT OK");
		$finish;
	end

endmodule
